@@ hw/rtl/lphash_pkg.sv @@
// shared types and constants for the linear probing hash table
`default_nettype none
package lphash_pkg;

  localparam int KEY_W  = 14;
  localparam int VAL_W  = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 3;
  localparam int OUT_W  = 4;
  // fraction bits of the key reciprocal, exact for every key up to 64 slots
  localparam int RECIP_SH = 20;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_RMISS    = 3'd4,
    ST_FOUND    = 3'd5,
    ST_SMISS    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_SCAN,
    S_PROBE
  } state_t;

  typedef struct packed {
    logic write;
    logic erase;
  } store_op_t;

endpackage
`default_nettype wire

@@ hw/rtl/lphash_mod.sv @@
// key remainder unit: reciprocal multiply, then multiply back and subtract
`default_nettype none
module lphash_mod #(
  parameter int SLOTS = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [lphash_pkg::KEY_W-1:0]  key,
  output logic                          fin,
  output logic [$clog2(SLOTS)-1:0]      home
);
  import lphash_pkg::*;

  localparam int IW  = $clog2(SLOTS);
  localparam int PRW = KEY_W + RECIP_SH;
  localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((2**RECIP_SH + SLOTS - 1) / SLOTS);

  logic [KEY_W-1:0] key_q;
  logic [PRW-1:0]   prod;
  logic             pend;
  logic [KEY_W-1:0] quo;
  logic [KEY_W-1:0] back;
  logic [KEY_W-1:0] diff;
  logic [IW-1:0]    home_q;

  assign quo  = prod[PRW-1:RECIP_SH];
  assign back = quo * KEY_W'(SLOTS);
  assign diff = key_q - back;
  assign home = home_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      fin  <= 1'b0;
    end else begin
      pend <= go;
      fin  <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      key_q <= key;
      prod  <= PRW'(key) * PRW'(RECIP);
    end
    // remainder is below SLOTS, so the low bits carry all of it
    if (pend) begin
      home_q <= diff[IW-1:0];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/lphash_store.sv @@
// key and value slot memories with per-slot occupied bits
`default_nettype none
module lphash_store #(
  parameter int SLOTS = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [$clog2(SLOTS)-1:0]      addr,
  input  lphash_pkg::store_op_t         op,
  input  logic [lphash_pkg::KEY_W-1:0]  wkey,
  input  logic [lphash_pkg::VAL_W-1:0]  wval,
  output logic                          rd_valid,
  output logic [lphash_pkg::KEY_W-1:0]  rd_key,
  output logic [lphash_pkg::VAL_W-1:0]  rd_val
);
  import lphash_pkg::*;

  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [VAL_W-1:0] val_mem [SLOTS];
  logic [SLOTS-1:0] occupied;

  // an unoccupied slot reads as empty, so reset needs no clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= occupied[addr];
      if (op.write) begin
        occupied[addr] <= 1'b1;
      end else if (op.erase) begin
        occupied[addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.write) begin
      key_mem[addr] <= wkey;
      val_mem[addr] <= wval;
    end
    rd_key <= key_mem[addr];
    rd_val <= val_mem[addr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/lphash_ctrl.sv @@
// sequencer: hashing, linear scan, probe from home, store update and result
`default_nettype none
module lphash_ctrl #(
  parameter int SLOTS = 13
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [lphash_pkg::CMD_W-1:0]   command,
  input  logic [lphash_pkg::KEY_W-1:0]   key,
  input  logic [lphash_pkg::VAL_W-1:0]   payload,
  output logic                           mod_go,
  input  logic                           mod_fin,
  input  logic [$clog2(SLOTS)-1:0]       home,
  output logic [$clog2(SLOTS)-1:0]       st_addr,
  output lphash_pkg::store_op_t          st_op,
  output logic [lphash_pkg::KEY_W-1:0]   st_wkey,
  output logic [lphash_pkg::VAL_W-1:0]   st_wval,
  input  logic                           rd_valid,
  input  logic [lphash_pkg::KEY_W-1:0]   rd_key,
  input  logic [lphash_pkg::VAL_W-1:0]   rd_val,
  output logic                           done,
  output logic [lphash_pkg::STAT_W-1:0]  status,
  output logic [lphash_pkg::OUT_W-1:0]   slot,
  output logic [lphash_pkg::OUT_W-1:0]   probe_count,
  output logic [lphash_pkg::VAL_W-1:0]   found_value
);
  import lphash_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = (IW > OUT_W) ? IW : OUT_W;
  localparam int PW = (CW > OUT_W) ? CW : OUT_W;

  state_t            state, state_next;
  logic [CMD_W-1:0]  cmd, cmd_next;
  logic [KEY_W-1:0]  key_q, key_q_next;
  logic [VAL_W-1:0]  pay_q, pay_q_next;
  logic [CW-1:0]     ai, ai_next;       // issued read count
  logic [IW-1:0]     pa, pa_next;       // probe read address
  logic              cv, cv_next;       // read data in flight is valid
  logic [IW-1:0]     ci, ci_next;       // slot of data in flight
  logic [CW-1:0]     cd, cd_next;       // distance of data in flight
  logic              done_next;
  status_t           status_q, status_next;
  logic [IW-1:0]     res_slot, res_slot_next;
  logic [CW-1:0]     res_pc, res_pc_next;
  logic [VAL_W-1:0]  res_val, res_val_next;

  logic              is_insert;
  logic              issue;
  logic              match;
  logic              empty;
  logic              last;
  logic [SW-1:0]     slot_ext;
  logic [PW-1:0]     pc_ext;

  assign busy        = (state != S_IDLE);
  assign st_wkey     = key_q;
  assign st_wval     = pay_q;
  assign is_insert   = (cmd == CMD_INSERT);
  assign issue       = (ai < CW'(SLOTS));
  assign match       = cv && rd_valid && (rd_key == key_q);
  assign empty       = cv && !rd_valid;
  assign last        = cv && (cd == CW'(SLOTS - 1));
  assign slot_ext    = SW'(res_slot);
  assign pc_ext      = PW'(res_pc);
  assign status      = status_q;
  assign slot        = slot_ext[OUT_W-1:0];
  assign probe_count = pc_ext[OUT_W-1:0];
  assign found_value = res_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cv    <= cv_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    key_q    <= key_q_next;
    pay_q    <= pay_q_next;
    ai       <= ai_next;
    pa       <= pa_next;
    ci       <= ci_next;
    cd       <= cd_next;
    status_q <= status_next;
    res_slot <= res_slot_next;
    res_pc   <= res_pc_next;
    res_val  <= res_val_next;
  end

  always_comb begin
    state_next    = state;
    cmd_next      = cmd;
    key_q_next    = key_q;
    pay_q_next    = pay_q;
    ai_next       = ai;
    pa_next       = pa;
    cv_next       = 1'b0;
    ci_next       = ci;
    cd_next       = cd;
    done_next     = 1'b0;
    status_next   = status_q;
    res_slot_next = res_slot;
    res_pc_next   = res_pc;
    res_val_next  = res_val;
    mod_go        = 1'b0;
    st_op         = '0;
    st_addr       = pa;

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_next   = command;
          key_q_next = key;
          pay_q_next = payload;
          ai_next    = '0;
          if (key == '0) begin
            // zero key never matches and is never stored
            done_next     = 1'b1;
            res_slot_next = '0;
            res_val_next  = '0;
            if (command == CMD_INSERT) begin
              status_next = ST_FULL;
              res_pc_next = CW'(SLOTS - 1);
            end else if (command == CMD_REMOVE) begin
              status_next = ST_RMISS;
              res_pc_next = '0;
            end else begin
              status_next = ST_SMISS;
              res_pc_next = CW'(SLOTS);
            end
          end else if (command == CMD_REMOVE) begin
            state_next = S_SCAN;
          end else begin
            mod_go     = 1'b1;
            state_next = S_HASH;
          end
        end
      end

      S_HASH: begin
        if (mod_fin) begin
          ai_next = '0;
          pa_next = home;
          if (is_insert) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_PROBE;
          end
        end
      end

      S_SCAN: begin
        // slots 0 upward, one read issued per cycle, compared in the cycle after
        st_addr = ai[IW-1:0];
        if (issue) begin
          ai_next = ai + 1'b1;
          cv_next = 1'b1;
          ci_next = ai[IW-1:0];
          cd_next = ai;
        end
        if (match) begin
          cv_next       = 1'b0;
          state_next    = S_IDLE;
          done_next     = 1'b1;
          res_pc_next   = '0;
          res_val_next  = '0;
          if (is_insert) begin
            status_next   = ST_DUP;
            res_slot_next = '0;
          end else begin
            st_addr       = ci;
            st_op.erase   = 1'b1;
            status_next   = ST_REMOVED;
            res_slot_next = ci;
          end
        end else if (last) begin
          cv_next = 1'b0;
          if (is_insert) begin
            ai_next    = '0;
            pa_next    = home;
            state_next = S_PROBE;
          end else begin
            state_next    = S_IDLE;
            done_next     = 1'b1;
            status_next   = ST_RMISS;
            res_slot_next = '0;
            res_pc_next   = '0;
            res_val_next  = '0;
          end
        end
      end

      S_PROBE: begin
        // from home with wraparound
        st_addr = pa;
        if (issue) begin
          ai_next = ai + 1'b1;
          pa_next = (pa == IW'(SLOTS - 1)) ? '0 : pa + 1'b1;
          cv_next = 1'b1;
          ci_next = pa;
          cd_next = ai;
        end
        if (is_insert ? empty : match) begin
          cv_next       = 1'b0;
          state_next    = S_IDLE;
          done_next     = 1'b1;
          res_slot_next = ci;
          if (is_insert) begin
            st_addr      = ci;
            st_op.write  = 1'b1;
            status_next  = ST_INSERTED;
            res_pc_next  = cd;
            res_val_next = '0;
          end else begin
            status_next  = ST_FOUND;
            res_pc_next  = cd + 1'b1;
            res_val_next = rd_val;
          end
        end else if (last) begin
          cv_next       = 1'b0;
          state_next    = S_IDLE;
          done_next     = 1'b1;
          res_slot_next = '0;
          res_val_next  = '0;
          if (is_insert) begin
            status_next = ST_FULL;
            res_pc_next = CW'(SLOTS - 1);
          end else begin
            status_next = ST_SMISS;
            res_pc_next = CW'(SLOTS);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/linear_probe_hash_table_top.sv @@
// top level of the linear probing hash table
//
//  channel   ports                                         handshake
//  request   command, key, payload                         start high, busy low
//  result    status, slot, probe_count, found_value        done, one cycle
//
// an insert scans the slots for a duplicate, then probes from the home
// slot; a search only probes and a remove only scans. each pass reads
// one slot a cycle through the single read port of the slot memories,
// after the reciprocal multiply gives an insert or search its home slot.
// on reset the occupied bits clear at once, so no sweep follows.
// the result is registered and shown on done while busy is already low;
// the receiver cannot stall it.
`default_nettype none
module linear_probe_hash_table_top #(
  parameter int SLOTS = 13
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [lphash_pkg::CMD_W-1:0]   command,
  input  logic [lphash_pkg::KEY_W-1:0]   key,
  input  logic [lphash_pkg::VAL_W-1:0]   payload,
  output logic                           done,
  output logic [lphash_pkg::STAT_W-1:0]  status,
  output logic [lphash_pkg::OUT_W-1:0]   slot,
  output logic [lphash_pkg::OUT_W-1:0]   probe_count,
  output logic [lphash_pkg::VAL_W-1:0]   found_value
);
  import lphash_pkg::*;

  localparam int IW = $clog2(SLOTS);

  logic             mod_go;
  logic             mod_fin;
  logic [IW-1:0]    home;
  logic [IW-1:0]    st_addr;
  store_op_t        st_op;
  logic [KEY_W-1:0] st_wkey;
  logic [VAL_W-1:0] st_wval;
  logic             rd_valid;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;

  lphash_mod #(.SLOTS(SLOTS)) u_mod (
    .clk  (clk),
    .rst  (rst),
    .go   (mod_go),
    .key  (key),
    .fin  (mod_fin),
    .home (home)
  );

  lphash_store #(.SLOTS(SLOTS)) u_store (
    .clk      (clk),
    .rst      (rst),
    .addr     (st_addr),
    .op       (st_op),
    .wkey     (st_wkey),
    .wval     (st_wval),
    .rd_valid (rd_valid),
    .rd_key   (rd_key),
    .rd_val   (rd_val)
  );

  lphash_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .key         (key),
    .payload     (payload),
    .mod_go      (mod_go),
    .mod_fin     (mod_fin),
    .home        (home),
    .st_addr     (st_addr),
    .st_op       (st_op),
    .st_wkey     (st_wkey),
    .st_wval     (st_wval),
    .rd_valid    (rd_valid),
    .rd_key      (rd_key),
    .rd_val      (rd_val),
    .done        (done),
    .status      (status),
    .slot        (slot),
    .probe_count (probe_count),
    .found_value (found_value)
  );

endmodule
`default_nettype wire

@@ sim/lphash_checker.sv @@
// request/result monitor and hash table predictor for the linear probing hash table
module lphash_checker #(
  parameter int SLOTS = 13
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [lphash_pkg::CMD_W-1:0]   command,
  input  logic [lphash_pkg::KEY_W-1:0]   key,
  input  logic [lphash_pkg::VAL_W-1:0]   payload,
  input  logic                           done,
  input  logic [lphash_pkg::STAT_W-1:0]  status,
  input  logic [lphash_pkg::OUT_W-1:0]   slot,
  input  logic [lphash_pkg::OUT_W-1:0]   probe_count,
  input  logic [lphash_pkg::VAL_W-1:0]   found_value,
  output int                             fails,
  output int                             pending,
  output int                             checked,
  output int                             hits,
  output int                             dups,
  output int                             fulls
);
  timeunit 1ns;
  timeprecision 1ps;
  import lphash_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [OUT_W-1:0] slot;
    logic [OUT_W-1:0] probes;
    logic [VAL_W-1:0] value;
  } outcome_t;

  logic [KEY_W-1:0] key_tab [SLOTS];
  logic [VAL_W-1:0] val_tab [SLOTS];
  outcome_t         outcome_q [$];
  int               err_cnt = 0;
  int               chk_cnt = 0;
  int               hit_cnt = 0;
  int               dup_cnt = 0;
  int               full_cnt = 0;

  assign fails   = err_cnt;
  assign pending = outcome_q.size();
  assign checked = chk_cnt;
  assign hits    = hit_cnt;
  assign dups    = dup_cnt;
  assign fulls   = full_cnt;

  // updates the shadow table and returns the result the block should give
  function automatic outcome_t apply_request(input logic [CMD_W-1:0] cmd,
                                             input logic [KEY_W-1:0] k,
                                             input logic [VAL_W-1:0] pay);
    outcome_t res;
    int       home;
    int       s;
    res  = '0;
    home = int'(k) % SLOTS;
    if (cmd == CMD_INSERT) begin
      res.status = ST_FULL;
      res.probes = OUT_W'(SLOTS - 1);
      if (k == '0) return res;
      for (int i = 0; i < SLOTS; i++) begin
        if (key_tab[i] == k) begin
          res.status = ST_DUP;
          res.probes = '0;
          return res;
        end
      end
      for (int d = 0; d < SLOTS; d++) begin
        s = (home + d) % SLOTS;
        if (key_tab[s] == '0) begin
          key_tab[s] = k;
          val_tab[s] = pay;
          res.status = ST_INSERTED;
          res.slot   = OUT_W'(s);
          res.probes = OUT_W'(d);
          return res;
        end
      end
      return res;
    end
    if (cmd == CMD_REMOVE) begin
      res.status = ST_RMISS;
      if (k == '0) return res;
      for (int i = 0; i < SLOTS; i++) begin
        if (key_tab[i] == k) begin
          key_tab[i] = '0;
          val_tab[i] = '0;
          res.status = ST_REMOVED;
          res.slot   = OUT_W'(i);
          return res;
        end
      end
      return res;
    end
    // search, both remaining command codes; does not stop at an empty slot
    res.status = ST_SMISS;
    res.probes = OUT_W'(SLOTS);
    if (k == '0) return res;
    for (int d = 0; d < SLOTS; d++) begin
      s = (home + d) % SLOTS;
      if (key_tab[s] == k) begin
        res.status = ST_FOUND;
        res.slot   = OUT_W'(s);
        res.probes = OUT_W'(d + 1);
        res.value  = val_tab[s];
        return res;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t exp_res;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        key_tab[i] = '0;
        val_tab[i] = '0;
      end
      outcome_q.delete();
    end else begin
      if (done) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding: status %0d slot %0d", status, slot);
          err_cnt++;
        end else begin
          exp_res = outcome_q.pop_front();
          chk_cnt++;
          if (status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, status);
            err_cnt++;
          end
          if (slot !== exp_res.slot) begin
            $error("slot: expected %0d, actual %0d", exp_res.slot, slot);
            err_cnt++;
          end
          if (probe_count !== exp_res.probes) begin
            $error("probe_count: expected %0d, actual %0d", exp_res.probes, probe_count);
            err_cnt++;
          end
          if (found_value !== exp_res.value) begin
            $error("found_value: expected %h, actual %h", exp_res.value, found_value);
            err_cnt++;
          end
          if (exp_res.status == ST_FOUND) hit_cnt++;
          if (exp_res.status == ST_DUP) dup_cnt++;
          if (exp_res.status == ST_FULL) full_cnt++;
        end
      end
      if (start && !busy) outcome_q.push_back(apply_request(command, key, payload));
    end
  end

endmodule

@@ sim/testbench.sv @@
// stimulus and verdict for the linear probing hash table
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lphash_pkg::*;

  localparam int SLOTS = 13;
  localparam int RANDOM_REQS = 825;
  localparam int POOL_SIZE = 24;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH_ALT = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [CMD_W-1:0]   command = '0;
  logic [KEY_W-1:0]   key = '0;
  logic [VAL_W-1:0]   payload = '0;
  logic               busy;
  logic               done;
  logic [STAT_W-1:0]  status;
  logic [OUT_W-1:0]   slot;
  logic [OUT_W-1:0]   probe_count;
  logic [VAL_W-1:0]   found_value;

  int fails, pending, checked, hits, dups, fulls;
  int issued = 0;
  bit no_gaps = 1'b0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  always #10 clk = ~clk;

  linear_probe_hash_table_top #(.SLOTS(SLOTS)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .key(key), .payload(payload),
    .done(done), .status(status), .slot(slot),
    .probe_count(probe_count), .found_value(found_value)
  );

  lphash_checker #(.SLOTS(SLOTS)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .key(key), .payload(payload),
    .done(done), .status(status), .slot(slot),
    .probe_count(probe_count), .found_value(found_value),
    .fails(fails), .pending(pending), .checked(checked),
    .hits(hits), .dups(dups), .fulls(fulls)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  // pool keys crowd a few home slots so probing chains and wraparound get exercised
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 95) return KEY_W'($urandom_range(1, 2**KEY_W - 1));
    if (r < 98) return '0;
    return KEY_MAX;
  endfunction

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                       input logic [VAL_W-1:0] pay);
    int gap;
    start   <= 1'b1;
    command <= cmd;
    key     <= k;
    payload <= pay;
    do @(posedge clk); while (busy);
    issued++;
    gap = pick_gap();
    if (gap > 0) begin
      start   <= 1'b0;
      command <= CMD_W'($urandom_range(0, 3));
      key     <= KEY_W'($urandom());
      payload <= $urandom();
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int home;
    int r;
    bit filling;
    logic [CMD_W-1:0] cmd;
    for (int i = 0; i < POOL_SIZE; i++) begin
      home = (i % 4 == 3) ? $urandom_range(0, SLOTS - 1) : (i % 4) * 6;
      key_pool[i] = KEY_W'(home + SLOTS * $urandom_range(1, 1259));
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, key zero, extremes, collisions, wraparound, full table
    issue(CMD_SEARCH, 14'd100, 32'h0);
    issue(CMD_REMOVE, 14'd100, 32'h0);
    issue(CMD_INSERT, 14'd0, 32'h1234_5678);
    issue(CMD_REMOVE, 14'd0, 32'h0);
    issue(CMD_SEARCH, 14'd0, 32'h0);
    issue(CMD_INSERT, KEY_MAX, 32'hFFFF_FFFF);
    issue(CMD_INSERT, 14'd13, 32'h0);
    issue(CMD_INSERT, 14'd26, 32'hA5A5_5A5A);
    issue(CMD_INSERT, 14'd12, 32'h0000_0001);
    issue(CMD_INSERT, 14'd25, 32'h8000_0000);
    issue(CMD_SEARCH, 14'd25, 32'h0);
    issue(CMD_INSERT, 14'd13, 32'hDEAD_BEEF);
    issue(CMD_SEARCH_ALT, 14'd26, 32'h0);
    issue(CMD_REMOVE, 14'd13, 32'h0);
    // the freed home slot must not end the search
    issue(CMD_SEARCH, 14'd26, 32'h0);
    for (int i = 1; i <= 10; i++) issue(CMD_INSERT, KEY_W'(5000 + i), $urandom());
    issue(CMD_SEARCH, KEY_MAX, 32'h0);

    // random: alternate fill-biased and drain-biased phases
    filling = 1'b0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 60 == 0) begin
        filling = ~filling;
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r >= 97) cmd = CMD_SEARCH_ALT;
      else if (r < (filling ? 55 : 20)) cmd = CMD_INSERT;
      else if (r < (filling ? 70 : 60)) cmd = CMD_REMOVE;
      else cmd = CMD_SEARCH;
      issue(cmd, pick_key(), $urandom());
    end

    start <= 1'b0;
    repeat (2) @(posedge clk);
    wait (pending == 0);
    repeat (60) @(posedge clk);
    $display("%0d requests sent, %0d results checked", issued, checked);
    $display("search hits %0d, duplicate inserts %0d, table full %0d", hits, dups, fulls);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
